// ===== rtl/cantxs_pkg.sv =====
`default_nettype none

package cantxs_pkg;

	// Number of transmit buffers in the table.
	localparam int TX_ENTRIES = 16;
	localparam int IDX_W      = (TX_ENTRIES > 1) ? $clog2(TX_ENTRIES) : 1;
	// The scan counter must also hold TX_ENTRIES itself.
	localparam int SCAN_W     = $clog2(TX_ENTRIES + 1);

	localparam int ID_W    = 11;
	localparam int LEN_W   = 4;
	localparam int ENTRY_W = 4;
	localparam int CNT_W   = 8;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam int S_DATA_W = 24;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 32;

	typedef enum logic [1:0] {
		FN_INIT,
		FN_SEND,
		FN_POLL,
		FN_CLEAR
	} func_t;

	typedef enum logic [1:0] {
		TXS_OK,
		TXS_OVERFLOW,
		TXS_WRITE_ERR
	} status_t;

	typedef enum logic [1:0] {
		DROP_NONE,
		DROP_INHIBIT,
		DROP_SYNC
	} drop_t;

	// One transmit buffer as it sits in the RAM.
	typedef struct packed {
		logic             sync;
		logic [LEN_W-1:0] len;
		logic             rtr;
		logic [ID_W-1:0]  id;
	} buf_t;

	localparam int BUF_W = $bits(buf_t);

	// Result of one request, lowest field in the lowest bits.
	typedef struct packed {
		logic [1:0]         sync_dropped;
		logic [LEN_W-1:0]   tx_len;
		logic               tx_rtr;
		logic [ID_W-1:0]    tx_id;
		logic [ENTRY_W-1:0] tx_entry;
		logic               tx_valid;
		logic               overflow_report;
		logic [1:0]         status;
	} result_t;

	localparam int RES_W = $bits(result_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_SEND_RD,
		S_SEND_EX,
		S_START,
		S_SCAN,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic init_wr;
		logic send_rd;
		logic send_ex;
		logic op_start;
		logic scan_run;
		logic finish_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		func_t in_func;
		logic  in_entry_ok;
		logic  scan_needed;
		logic  scan_done;
		logic  out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/cantxs_ram.sv =====
`default_nettype none

module cantxs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/cantxs_ctrl.sv =====
`default_nettype none

module cantxs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  cantxs_pkg::sts_t  sts,
	output cantxs_pkg::cmd_t  cmd
);

	import cantxs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (sts.in_func)
						FN_INIT:  state_d = sts.in_entry_ok ? S_INIT : S_FINISH;
						FN_SEND:  state_d = sts.in_entry_ok ? S_SEND_RD : S_FINISH;
						default:  state_d = S_START;
					endcase
				end
			end
			S_INIT:    state_d = S_FINISH;
			S_SEND_RD: state_d = S_SEND_EX;
			S_SEND_EX: state_d = S_FINISH;
			S_START:   state_d = sts.scan_needed ? S_SCAN : S_FINISH;
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// Commands.
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:    cmd.capture     = accept;
			S_INIT:    cmd.init_wr     = 1'b1;
			S_SEND_RD: cmd.send_rd     = 1'b1;
			S_SEND_EX: cmd.send_ex     = 1'b1;
			S_START:   cmd.op_start    = 1'b1;
			S_SCAN:    cmd.scan_run    = 1'b1;
			S_FINISH:  cmd.finish_load = sts.out_free;
			default:   cmd = '0;
		endcase
	end

	// A taken request always leaves idle.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted request did not leave idle");

endmodule

`default_nettype wire

// ===== rtl/cantxs_dp.sv =====
`default_nettype none

module cantxs_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cantxs_pkg::cmd_t                   cmd,
	output cantxs_pkg::sts_t                   sts,
	input  logic [cantxs_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic [cantxs_pkg::S_USER_W-1:0]    s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [cantxs_pkg::M_DATA_W-1:0]    m_tdata
);

	import cantxs_pkg::*;

	// Captured request.
	func_t              op_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [ID_W-1:0]    id_q;
	logic               rtr_q;
	logic [LEN_W-1:0]   len_q;
	logic               sync_q;
	logic               room_q;
	logic               ok_q;

	// Scheduler state.
	logic [TX_ENTRIES-1:0] pending_q;
	logic [TX_ENTRIES-1:0] pending_d;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic                  inhibit_q;
	logic                  inhibit_d;
	logic                  first_q;
	logic                  first_d;

	// Scan over the table.
	logic [SCAN_W-1:0] scan_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_addr_s1;
	logic              scan_more;
	logic              scan_issue;

	result_t res_q;
	result_t res_d;
	result_t m_res_q;
	logic    m_tvalid_q;

	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] ram_raddr;
	logic [BUF_W-1:0] ram_rdata;
	buf_t             rbuf;
	buf_t             wbuf;
	logic             pend_e;
	logic             pend_s;
	logic             eval;
	logic             poll_hit;
	logic             last_eval;

	assign idx    = IDX_W'(entry_q);
	assign rbuf   = buf_t'(ram_rdata);
	assign pend_e = pending_q[idx];
	assign pend_s = pending_q[rd_addr_s1];

	assign eval      = cmd.scan_run && rd_vld_s1;
	assign poll_hit  = eval && (op_q == FN_POLL) && pend_s;
	assign last_eval = eval && (rd_addr_s1 == IDX_W'(TX_ENTRIES - 1));
	assign scan_more = scan_q < SCAN_W'(TX_ENTRIES);
	assign scan_issue = cmd.scan_run && scan_more && !sts.scan_done;

	always_comb begin
		sts.in_func     = func_t'(s_tuser);
		sts.in_entry_ok = int'(s_tdata[3:0]) < TX_ENTRIES;
		sts.scan_needed = (op_q == FN_POLL) ? (room_q && (count_q != '0)) : (count_q != '0);
		sts.scan_done   = poll_hit || last_eval;
		sts.out_free    = !m_tvalid_q || m_tready;
	end

	assign wbuf.sync = sync_q;
	assign wbuf.len  = len_q;
	assign wbuf.rtr  = rtr_q;
	assign wbuf.id   = id_q;

	assign ram_raddr = cmd.send_rd ? idx : scan_q[IDX_W-1:0];

	cantxs_ram #(
		.WIDTH (BUF_W),
		.DEPTH (TX_ENTRIES)
	) u_buf_ram (
		.clk   (clk),
		.we    (cmd.init_wr),
		.waddr (idx),
		.wdata (wbuf),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Next values of the scheduler state and of the result under construction.
	always_comb begin
		pending_d = pending_q;
		count_d   = count_q;
		inhibit_d = inhibit_q;
		first_d   = first_q;
		res_d     = res_q;

		if (cmd.capture) begin
			res_d = '0;
		end

		if (cmd.init_wr) begin
			pending_d[idx] = 1'b0;
		end

		if (cmd.send_ex) begin
			res_d.status          = pend_e ? TXS_OVERFLOW : TXS_OK;
			res_d.overflow_report = pend_e && !first_q;
			if ((count_q == '0) && room_q) begin
				inhibit_d      = rbuf.sync;
				res_d.tx_valid = 1'b1;
				res_d.tx_entry = ENTRY_W'(idx);
				res_d.tx_id    = rbuf.id;
				res_d.tx_rtr   = rbuf.rtr;
				res_d.tx_len   = rbuf.len;
				if (!ok_q) begin
					res_d.status = TXS_WRITE_ERR;
				end
			end else begin
				pending_d[idx] = 1'b1;
				if (count_q != CNT_MAX) begin
					count_d = count_q + 1'b1;
				end
			end
		end

		if (cmd.op_start) begin
			if (op_q == FN_POLL) begin
				if (room_q) begin
					first_d   = 1'b0;
					inhibit_d = 1'b0;
				end
			end else if (inhibit_q) begin
				inhibit_d          = 1'b0;
				res_d.sync_dropped = DROP_INHIBIT;
			end
		end

		if (eval) begin
			if (op_q == FN_POLL) begin
				if (pend_s) begin
					inhibit_d      = rbuf.sync;
					res_d.tx_valid = 1'b1;
					res_d.tx_entry = ENTRY_W'(rd_addr_s1);
					res_d.tx_id    = rbuf.id;
					res_d.tx_rtr   = rbuf.rtr;
					res_d.tx_len   = rbuf.len;
					if (ok_q) begin
						pending_d[rd_addr_s1] = 1'b0;
						count_d               = count_q - 1'b1;
					end
				end else if (last_eval) begin
					// Nothing pending after all: the count was stale.
					count_d = '0;
				end
			end else if (pend_s && rbuf.sync) begin
				pending_d[rd_addr_s1] = 1'b0;
				if (count_q != '0) begin
					count_d = count_q - 1'b1;
				end
				res_d.sync_dropped = DROP_SYNC;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			count_q    <= '0;
			inhibit_q  <= 1'b0;
			first_q    <= 1'b1;
			scan_q     <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			pending_q <= pending_d;
			count_q   <= count_d;
			inhibit_q <= inhibit_d;
			first_q   <= first_d;
			if (cmd.op_start) begin
				scan_q    <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= scan_issue;
				if (scan_issue) begin
					scan_q <= scan_q + 1'b1;
				end
			end
			if (cmd.finish_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= func_t'(s_tuser);
			entry_q <= s_tdata[3:0];
			id_q    <= s_tdata[14:4];
			rtr_q   <= s_tdata[15];
			len_q   <= s_tdata[19:16];
			sync_q  <= s_tdata[20];
			room_q  <= s_tdata[21];
			ok_q    <= s_tdata[22];
		end
		if (scan_issue) begin
			rd_addr_s1 <= scan_q[IDX_W-1:0];
		end
		res_q <= res_d;
		if (cmd.finish_load) begin
			m_res_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_DATA_W - RES_W)'(0), m_res_q};

	// Every pending buffer is counted at least once.
	a_count_covers_pending: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(pending_q) <= int'(count_q))
		else $error("pending count below number of pending buffers");

	// A poll whose frame the hardware took retires that buffer.
	a_poll_retires: assert property (@(posedge clk) disable iff (!arst_n)
		(poll_hit && ok_q) |=> !pending_q[$past(rd_addr_s1)])
		else $error("polled buffer still pending after accepted write");

	// A frame handed to hardware never comes with a sync drop report.
	a_tx_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_res_q.tx_valid) |-> (m_res_q.sync_dropped == DROP_NONE))
		else $error("transmit result carries a sync drop report");

endmodule

`default_nettype wire

// ===== rtl/can_tx_buffer_scheduler.sv =====
// CAN transmit buffer scheduler.
// Requests enter on the s_ stream: s_tuser carries the operation (init, send,
// poll or clear) and s_tdata the buffer index, the frame header to program,
// and the hardware room and write acknowledge flags. Every request yields
// exactly one result on the m_ stream, in request order.
// An init request passes through a write state, a send request through a
// RAM read state and an evaluate state, and a poll or clear through a start
// state and, if a scan is needed, a scan state, before its result is loaded.
// The scan walks the buffer RAM one entry a cycle through its registered
// read port; a poll stops at the lowest pending buffer. One request is in
// work at a time, so a new request is taken only once the last result has
// been loaded into the output register.
// A finished result sits in an output register, so the next request is taken
// while the receiver still holds off m_tready. If the output register is
// still full when the next result is ready, the block waits and takes no
// further request until the receiver drains it.
// Reset clears all pending flags and the pending count, drops the sync
// inhibit and marks the first message as not yet sent; buffer headers are
// undefined until programmed by an init request. No reset sweep is needed.
`default_nettype none

module can_tx_buffer_scheduler (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// entry, can_id, remote_req, byte_count, sync_bit, hw_room, write_ok, zero pad
	input  logic [cantxs_pkg::S_DATA_W-1:0]        s_tdata,
	// func
	input  logic [cantxs_pkg::S_USER_W-1:0]        s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// status, overflow_report, tx_valid, tx_entry, tx_id, tx_rtr, tx_len,
	// sync_dropped, zero pad
	output logic [cantxs_pkg::M_DATA_W-1:0]        m_tdata
);

	import cantxs_pkg::*;

	// The controller sequences each request; the datapath holds the buffer RAM,
	// the pending flags and counters, and the output register.
	cmd_t cmd;
	sts_t sts;

	cantxs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cantxs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire
